// ===== hw/rtl/fast_gelu_activation_core_defines.svh =====
// Assertion macros for the fast GELU core.
`ifndef FAST_GELU_ACTIVATION_CORE_DEFINES_SVH
`define FAST_GELU_ACTIVATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FGA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fast gelu assertion failed");
`define FGA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fast gelu assertion failed");
`else
`define FGA_ASSERT(lbl, clk, rst_n, prop)
`define FGA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/fga_pkg.sv =====
`default_nettype none
package fga_pkg;

    localparam int KLOG_W = 18;
    localparam logic [KLOG_W-1:0] KLOG = 18'd160921;
    localparam int TAB_W = 17;

    function automatic logic [TAB_W-1:0] pow2_tab(input logic [4:0] i);
        logic [TAB_W-1:0] t;
        begin
            case (i)
                5'd0:    t = 17'd65536;
                5'd1:    t = 17'd62757;
                5'd2:    t = 17'd60097;
                5'd3:    t = 17'd57549;
                5'd4:    t = 17'd55109;
                5'd5:    t = 17'd52773;
                5'd6:    t = 17'd50535;
                5'd7:    t = 17'd48393;
                5'd8:    t = 17'd46341;
                5'd9:    t = 17'd44376;
                5'd10:   t = 17'd42495;
                5'd11:   t = 17'd40693;
                5'd12:   t = 17'd38968;
                5'd13:   t = 17'd37316;
                5'd14:   t = 17'd35734;
                5'd15:   t = 17'd34219;
                5'd16:   t = 17'd32768;
                default: t = 17'd32768;
            endcase
            return t;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fga_stream_if.sv =====
`default_nettype none
interface fga_in_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_in;
    modport source (output valid, output x_in, input ready);
    modport sink   (input valid, input x_in, output ready);
endinterface

interface fga_out_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] y_out;
    modport source (output valid, output y_out, input ready);
    modport sink   (input valid, input y_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fast_gelu_activation_core.sv =====
// Fast GELU core: y = x * sigmoid(1.702 x) on signed fixed-point samples.
// Channels: sample (sink, field x_in) and result (source, field y_out), both
// valid/ready; a beat moves on a clock edge with valid and ready high.
// Both fields are DATA_WIDTH-bit two's complement with FRAC_BITS fraction bits.
// Throughput: one beat per cycle in and out while result.ready is high.
// Pipeline stages: magnitude and log2 scaling, table interpolation, exponent
// shift, numerator multiply, one stage per quotient bit of the restoring
// divider, output sign and saturation register.
// Each stage holds its own valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled result holds in place
// while earlier stages keep filling. sample.ready drops only when every stage
// holds a beat and result.ready is low.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
`include "fast_gelu_activation_core_defines.svh"
module fast_gelu_activation_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input wire         clk,
    input wire         rst_n,
    fga_in_if.sink     sample,
    fga_out_if.source  result
);
    import fga_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = DW + KLOG_W + 1;
    localparam int ZW   = (DW + KLOG_W + 1 - FRAC_BITS > 17) ? DW + KLOG_W + 1 - FRAC_BITS : 17;
    localparam int NUMW = DW + 17;
    localparam int RW   = DW + 19;
    localparam int DVW  = 19;
    localparam int S    = DW + 5;

    localparam logic [DW-1:0] HALF = DW'(1) << (DW - 1);
    localparam logic [DW-1:0] MAXP = HALF - DW'(1);

    logic [S-1:0] v_reg;
    logic [S-1:0] en;

    assign en[S-1] = !v_reg[S-1] || result.ready;
    genvar g;
    generate
        for (g = 0; g < S - 1; g++) begin : g_en
            assign en[g] = !v_reg[g] || en[g+1];
        end
    endgenerate

    assign sample.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= sample.valid;
            end
            for (int k = 1; k < S; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: magnitude and scaled exponent
    logic [DW-1:0] raw0;
    logic [DW-1:0] mag0_next;
    logic [PW-1:0] zsum0;
    logic          neg0_reg;
    logic [DW-1:0] mag0_reg;
    logic [ZW-1:0] z0_reg;

    always_comb
    begin
        raw0      = sample.x_in;
        mag0_next = raw0[DW-1] ? DW'(~raw0 + DW'(1)) : raw0;
        zsum0     = PW'(mag0_next) * PW'(KLOG) + (PW'(1) << (FRAC_BITS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg0_reg <= raw0[DW-1];
            mag0_reg <= mag0_next;
            z0_reg   <= ZW'(zsum0 >> FRAC_BITS);
        end
    end

    // stage 1: table lookup and interpolation product
    logic [3:0]       idx1;
    logic [TAB_W-1:0] hi1;
    logic [TAB_W-1:0] lo1;
    logic [11:0]      diff1;
    logic             neg1_reg;
    logic [DW-1:0]    mag1_reg;
    logic [TAB_W-1:0] hi1_reg;
    logic [23:0]      prod1_reg;
    logic [4:0]       sh1_reg;
    logic             nbig1_reg;

    always_comb
    begin
        idx1  = z0_reg[15:12];
        hi1   = pow2_tab({1'b0, idx1});
        lo1   = pow2_tab(5'({1'b0, idx1} + 5'd1));
        diff1 = 12'(hi1 - lo1);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            neg1_reg  <= neg0_reg;
            mag1_reg  <= mag0_reg;
            hi1_reg   <= hi1;
            prod1_reg <= 24'(diff1) * 24'(z0_reg[11:0]);
            sh1_reg   <= 5'(z0_reg >> 16);
            nbig1_reg <= (z0_reg >> 16) >= ZW'(17);
        end
    end

    // stage 2: exponential
    logic [TAB_W-1:0] p2;
    logic             neg2_reg;
    logic [DW-1:0]    mag2_reg;
    logic [TAB_W-1:0] e2_reg;

    assign p2 = hi1_reg - TAB_W'((prod1_reg + 24'd2048) >> 12);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            e2_reg   <= nbig1_reg ? '0 : (p2 >> sh1_reg);
        end
    end

    // stage 3: numerator and divisor
    logic [NUMW-1:0] num3;
    logic [17:0]     den3;

    always_comb
    begin
        num3 = neg2_reg ? NUMW'(mag2_reg) * NUMW'(e2_reg) : (NUMW'(mag2_reg) << 16);
        den3 = 18'(e2_reg) + 18'd65536;
    end

    logic [RW-1:0]  rem_reg  [DW+1];
    logic [DVW-1:0] dv_reg   [DW+1];
    logic [DW-1:0]  q_reg    [DW+1];
    logic           dneg_reg [DW+1];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rem_reg[0]  <= (RW'(num3) << 1) + RW'(den3);
            dv_reg[0]   <= {den3, 1'b0};
            q_reg[0]    <= '0;
            dneg_reg[0] <= neg2_reg;
        end
    end

    // restoring divider: one quotient bit per stage
    generate
        for (g = 0; g < DW; g++) begin : g_div
            logic [RW-1:0] trial;
            logic          ge;
            assign trial = RW'(dv_reg[g]) << (DW - 1 - g);
            assign ge    = rem_reg[g] >= trial;
            always_ff @(posedge clk)
            begin
                if (en[4+g])
                begin
                    rem_reg[g+1]  <= ge ? rem_reg[g] - trial : rem_reg[g];
                    dv_reg[g+1]   <= dv_reg[g];
                    q_reg[g+1]    <= {q_reg[g][DW-2:0], ge};
                    dneg_reg[g+1] <= dneg_reg[g];
                end
            end
        end
    endgenerate

    // output stage: sign and saturate
    logic [DW-1:0] qf;
    logic [DW-1:0] qc;
    logic [DW-1:0] y_next;
    logic [DW-1:0] y_reg;
    logic          neg_out_reg;

    always_comb
    begin
        qf = q_reg[DW];
        if (dneg_reg[DW])
        begin
            qc     = (qf > HALF) ? HALF : qf;
            y_next = DW'(~qc + DW'(1));
        end
        else
        begin
            qc     = qf;
            y_next = (qf > MAXP) ? MAXP : qf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S-1])
        begin
            y_reg       <= y_next;
            neg_out_reg <= dneg_reg[DW];
        end
    end

    assign result.valid = v_reg[S-1];
    assign result.y_out = y_reg;

    `FGA_ASSERT_IMPL(a_ready_only_on_stall, clk, rst_n, !sample.ready, result.valid && !result.ready)
    `FGA_ASSERT_IMPL(a_div_rem_below, clk, rst_n, v_reg[S-2], rem_reg[DW] < RW'(dv_reg[DW]))
    `FGA_ASSERT_IMPL(a_pos_sign, clk, rst_n, result.valid && !neg_out_reg, !y_reg[DW-1])

endmodule
`default_nettype wire

// ===== verif/tb_fast_gelu_activation_core.sv =====
`default_nettype none
module tb_fast_gelu_activation_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW          = 16;
    localparam int NUM_RANDOM  = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 40;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [DW-1:0] sample_t;

    typedef struct {
        sample_t x;
        bit      typed;
        sample_t y;
    } gelu_row_t;

    localparam logic [16:0] EXP2_NEG [0:16] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fga_in_if  #(.DATA_WIDTH(DW)) in_if ();
    fga_out_if #(.DATA_WIDTH(DW)) out_if ();

    fast_gelu_activation_core #(.DATA_WIDTH(DW), .FRAC_BITS(12)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_if.sink),
        .result (out_if.source)
    );

    gelu_row_t stim[$];
    sample_t   gelu_q[$];
    int        sent_cnt = 0;
    int        recv_cnt = 0;
    int        err_cnt = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    longint    cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic sample_t gelu_fixed(sample_t x);
        logic [63:0] mag, z, n, f, idx, r, hi, lo, p, e, den, num, q;
        logic        neg;
        begin
            neg = x[DW-1];
            mag = neg ? (64'd1 << DW) - {48'd0, x} : {48'd0, x};
            z   = (mag * 64'd160921 + 64'd2048) >> 12;
            n   = z >> 16;
            f   = z & 64'hFFFF;
            idx = (f >> 12) & 64'hF;
            r   = f & 64'hFFF;
            hi  = EXP2_NEG[idx];
            lo  = EXP2_NEG[idx + 1];
            p   = hi - (((hi - lo) * r + 64'd2048) >> 12);
            e   = (n >= 17) ? 64'd0 : (p >> n);
            den = 64'd65536 + e;
            num = mag * (neg ? e : 64'd65536);
            q   = (2 * num + den) / (2 * den);
            if (q > 64'd32768)
                q = 64'd32768;
            if (neg)
                return (q == 64'd32768) ? sample_t'(-32768) : sample_t'(-$signed(q[DW-1:0]));
            if (q > 64'd32767)
                q = 64'd32767;
            return sample_t'(q[DW-1:0]);
        end
    endfunction

    function automatic void add_row(sample_t x, bit typed, sample_t y);
        gelu_row_t row;
        begin
            row.x = x;
            row.typed = typed;
            row.y = y;
            stim.push_back(row);
        end
    endfunction

    function automatic int sender_idle_pct();
        return (sent_cnt < 450) ? 32 : (sent_cnt < 900) ? 83 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (recv_cnt < 450) ? 83 : (recv_cnt < 900) ? 32 : 0;
    endfunction

    // sender
    always @(posedge clk)
    begin
        int nxt;
        bit take;
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
        end
        else
        begin
            nxt = sent_cnt;
            take = !in_if.valid;
            if (in_if.valid && in_if.ready)
            begin
                gelu_q.push_back(stim[sent_cnt].typed ? stim[sent_cnt].y
                                                      : gelu_fixed(stim[sent_cnt].x));
                nxt = sent_cnt + 1;
                sent_cnt <= nxt;
                take = 1'b1;
            end
            if (take)
            begin
                if (nxt < stim.size() && $urandom_range(99) >= sender_idle_pct())
                begin
                    in_if.valid <= 1'b1;
                    in_if.x_in  <= stim[nxt].x;
                end
                else
                begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        sample_t want;
        int rc;
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            rc = recv_cnt;
            if (out_if.valid && out_if.ready)
            begin
                if (gelu_q.size() == 0)
                begin
                    $error("y_out: unexpected beat, actual %0d", out_if.y_out);
                    err_cnt++;
                end
                else
                begin
                    want = gelu_q.pop_front();
                    if (out_if.y_out !== want)
                    begin
                        $error("y_out: expected %0d actual %0d", want, out_if.y_out);
                        err_cnt++;
                    end
                end
                rc = recv_cnt + 1;
                recv_cnt <= rc;
            end
            if (!hold_done && rc >= 1000)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL fast_gelu_activation_core");
            $finish;
        end
    end

    initial
    begin
        int v;
        in_if.valid  = 1'b0;
        in_if.x_in   = '0;
        out_if.ready = 1'b0;

        add_row(16'sd0,      1'b1, 16'sd0);
        add_row(-16'sd32768, 1'b1, 16'sd0);
        add_row(16'sd32767,  1'b1, 16'sd32767);
        add_row(-16'sd32767, 1'b1, 16'sd0);
        add_row(16'sd1,      1'b0, '0);
        add_row(-16'sd1,     1'b0, '0);
        add_row(16'sd4096,   1'b0, '0);
        add_row(-16'sd4096,  1'b0, '0);
        add_row(16'sd2048,   1'b0, '0);
        add_row(-16'sd2048,  1'b0, '0);
        add_row(-16'sd12288, 1'b0, '0);
        add_row(-16'sd16384, 1'b0, '0);
        add_row(16'sd16384,  1'b0, '0);
        add_row(16'sh5555,   1'b0, '0);
        add_row(16'shAAAA,   1'b0, '0);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            case ($urandom_range(3))
                0: v = $urandom_range(16383) - 8192;
                1: v = $urandom_range(255) - 128;
                default: v = $urandom_range(65535);
            endcase
            add_row(sample_t'(v), 1'b0, '0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_cnt == stim.size());
        wait (gelu_q.size() == 0);
        repeat (DRAIN) @(posedge clk);

        $display("Ran %0d samples (%0d checked) through three idle mixes and one long",
                 stim.size(), recv_cnt);
        $display("result stall; zero, both extremes and deep negative underflow included.");
        if (err_cnt == 0 && gelu_q.size() == 0)
            $display("PASS fast_gelu_activation_core");
        else
            $display("FAIL fast_gelu_activation_core");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fga_pkg.sv
hw/rtl/fga_stream_if.sv
hw/rtl/fast_gelu_activation_core.sv
verif/tb_fast_gelu_activation_core.sv
